// ===== rtl/v4n_pkg.sv =====
// Shared widths and parameter defaults for the vector normalizer.
`default_nettype none
package v4n_pkg;
  localparam int DefInWidth  = 16;
  localparam int DefUnitFrac = 14;
endpackage
`default_nettype wire

// ===== rtl/vec4_normalize.sv =====
// Vector normalizer: magnitude and unit vector of a four-component vector.
// Pipeline: stage 1, stage 2, square-root chain, divider chain, output register.
// Throughput: one transaction per cycle unless stalled; sqrt and divider chains set latency.
// A stall freezes the whole pipeline; the output register holds its transaction.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none
module vec4_normalize #(
  parameter int IN_WIDTH  = v4n_pkg::DefInWidth,
  parameter int UNIT_FRAC = v4n_pkg::DefUnitFrac
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [IN_WIDTH-1:0]  x_in,
  input  wire logic signed [IN_WIDTH-1:0]  y_in,
  input  wire logic signed [IN_WIDTH-1:0]  z_in,
  input  wire logic signed [IN_WIDTH-1:0]  w_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [IN_WIDTH:0]                length_out,
  output logic signed [UNIT_FRAC+1:0]      unit_x,
  output logic signed [UNIT_FRAC+1:0]      unit_y,
  output logic signed [UNIT_FRAC+1:0]      unit_z,
  output logic signed [UNIT_FRAC+1:0]      unit_w,
  output logic                             zero_vector
);
  import v4n_pkg::*;

  localparam int AW  = IN_WIDTH + 1;          // magnitude of a component
  localparam int SQW = 2 * AW;
  localparam int SW  = 2 * IN_WIDTH + 2;      // sum of four squares
  localparam int LW  = IN_WIDTH + 1;          // root width
  localparam int NW  = AW + UNIT_FRAC;        // divider numerator
  localparam int QW  = UNIT_FRAC + 1;         // quotient magnitude
  localparam int TW  = 4 * AW + 4;            // magnitudes plus signs

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: absolute values and squares.
  logic              s1_vld;
  logic [AW-1:0]     s1_abs [4];
  logic [3:0]        s1_neg;
  logic [SQW-1:0]    s1_sq  [4];
  logic signed [IN_WIDTH-1:0] comp [4];
  assign comp[0] = x_in;
  assign comp[1] = y_in;
  assign comp[2] = z_in;
  assign comp[3] = w_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        logic [AW-1:0] a;
        a = comp[l][IN_WIDTH-1] ? AW'(-{comp[l][IN_WIDTH-1], comp[l]})
                                : AW'({1'b0, comp[l]});
        s1_abs[l] <= a;
        s1_neg[l] <= comp[l][IN_WIDTH-1];
        s1_sq[l]  <= a * a;
      end
    end
  end

  // Stage 2: sum of squares.
  logic              s2_vld;
  logic [SW-1:0]     s2_sum;
  logic [TW-1:0]     s2_tag;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
    if (adv) begin
      s2_sum <= (SW'(s1_sq[0]) + SW'(s1_sq[1])) + (SW'(s1_sq[2]) + SW'(s1_sq[3]));
      s2_tag <= {s1_neg, s1_abs[3], s1_abs[2], s1_abs[1], s1_abs[0]};
    end
  end

  logic          sq_vld;
  logic [LW-1:0] sq_root;
  logic [TW-1:0] sq_tag;
  v4n_sqrt #(.SW(SW), .RW(LW), .TW(TW)) u_sqrt (
    .clk, .rst, .adv,
    .in_vld(s2_vld), .in_sum(s2_sum), .in_tag(s2_tag),
    .out_vld(sq_vld), .out_root(sq_root), .out_tag(sq_tag)
  );

  logic [NW-1:0] dnum [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      dnum[l] = {sq_tag[l*AW +: AW], {UNIT_FRAC{1'b0}}};
    end
  end

  logic          dv_vld;
  logic [QW-1:0] dv_q [4];
  logic [LW+4:0] dv_tag;
  v4n_div #(.NW(NW), .DW(LW), .QW(QW), .TW(LW+5)) u_div (
    .clk, .rst, .adv,
    .in_vld(sq_vld), .in_num(dnum), .in_den(sq_root),
    .in_tag({sq_tag[TW-1 -: 4], (sq_root == '0), sq_root}),
    .out_vld(dv_vld), .out_q(dv_q), .out_tag(dv_tag)
  );

  // Output register: apply signs and the zero-vector override.
  logic [UNIT_FRAC+1:0] uv [4];
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld;
    end
    if (adv) begin
      length_out  <= dv_tag[LW-1:0];
      zero_vector <= dv_tag[LW];
      for (int l = 0; l < 4; l++) begin
        logic [UNIT_FRAC+1:0] qe;
        qe = {1'b0, dv_q[l]};
        if (dv_tag[LW])           uv[l] <= '0;
        else if (dv_tag[LW+1+l])  uv[l] <= -qe;
        else                      uv[l] <= qe;
      end
    end
  end

  assign unit_x = uv[0];
  assign unit_y = uv[1];
  assign unit_z = uv[2];
  assign unit_w = uv[3];
endmodule
`default_nettype wire

// ===== rtl/v4n_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module v4n_sqrt #(
  parameter int SW = 34,
  parameter int RW = 17,
  parameter int TW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_vld,
  input  wire logic [SW-1:0] in_sum,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_vld,
  output logic [RW-1:0]      out_root,
  output logic [TW-1:0]      out_tag
);
  // Each stage decides one root bit, MSB first, against the running remainder.
  localparam int NS = RW;
  localparam int RMW = SW + 2;

  logic [NS:0]          vld;
  logic [RMW-1:0]       rem  [NS+1];
  logic [RW-1:0]        root [NS+1];
  logic [SW-1:0]        sum  [NS+1];
  logic [TW-1:0]        tag  [NS+1];

  always_comb begin
    vld[0]  = in_vld;
    rem[0]  = '0;
    root[0] = '0;
    sum[0]  = in_sum;
    tag[0]  = in_tag;
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    localparam int B = NS - 1 - s;
    logic [RMW-1:0] r2;
    logic [RMW-1:0] trial;
    always_comb begin
      // Bring down the next two bits of the radicand.
      r2 = {rem[s][RMW-3:0], 2'b00};
      if (2*B+1 < SW) r2[1] = sum[s][2*B+1];
      if (2*B < SW)   r2[0] = sum[s][2*B];
      trial = {{(RMW-RW-2){1'b0}}, root[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
      if (adv) begin
        sum[s+1] <= sum[s];
        tag[s+1] <= tag[s];
        if (r2 >= trial) begin
          rem[s+1]  <= r2 - trial;
          root[s+1] <= {root[s][RW-2:0], 1'b1};
        end else begin
          rem[s+1]  <= r2;
          root[s+1] <= {root[s][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld[NS];
  assign out_root = root[NS];
  assign out_tag  = tag[NS];
endmodule
`default_nettype wire

// ===== rtl/v4n_div.sv =====
// Pipelined restoring divider for four lanes sharing one divisor.
`default_nettype none
module v4n_div #(
  parameter int NW = 30,
  parameter int DW = 17,
  parameter int QW = 15,
  parameter int TW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] in_num [4],
  input  wire logic [DW-1:0] in_den,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_vld,
  output logic [QW-1:0]      out_q  [4],
  output logic [TW-1:0]      out_tag
);
  // Quotient never exceeds 2^(QW-1), so only the low QW quotient bits are formed.
  localparam int RW = DW + 1;
  logic [QW:0]     vld;
  logic [RW-1:0]   rem [QW+1][4];
  logic [QW-1:0]   q   [QW+1][4];
  logic [NW-1:0]   num [QW+1][4];
  logic [DW-1:0]   den [QW+1];
  logic [TW-1:0]   tag [QW+1];

  always_comb begin
    vld[0] = in_vld;
    den[0] = in_den;
    tag[0] = in_tag;
    for (int l = 0; l < 4; l++) begin
      num[0][l] = in_num[l];
      q[0][l]   = '0;
      // Numerator bits above the quotient range form the starting remainder.
      rem[0][l] = RW'(in_num[l] >> QW);
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_st
    localparam int B = QW - 1 - s;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
      if (adv) begin
        den[s+1] <= den[s];
        tag[s+1] <= tag[s];
      end
    end
    for (genvar l = 0; l < 4; l++) begin : g_ln
      logic [RW-1:0] r2;
      assign r2 = {rem[s][l][RW-2:0], num[s][l][B]};
      always_ff @(posedge clk) begin
        if (adv) begin
          num[s+1][l] <= num[s][l];
          if (r2 >= {1'b0, den[s]}) begin
            rem[s+1][l] <= r2 - {1'b0, den[s]};
            q[s+1][l]   <= {q[s][l][QW-2:0], 1'b1};
          end else begin
            rem[s+1][l] <= r2;
            q[s+1][l]   <= {q[s][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_vld = vld[QW];
  assign out_q   = q[QW];
  assign out_tag = tag[QW];
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the vector normalizer: directed table, then random bursts.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int InW = v4n_pkg::DefInWidth;
  localparam int UFrac = v4n_pkg::DefUnitFrac;
  localparam int NumRandom = 930;
  localparam int IdleLimit = 5000;
  localparam int Latency = 2 + (InW + 1) + (UFrac + 1) + 1;

  typedef logic signed [InW-1:0] comp_t;
  typedef logic signed [UFrac+1:0] unit_t;

  typedef struct packed {
    logic [InW:0] length;
    unit_t ux, uy, uz, uw;
    logic zero;
  } norm_t;

  typedef struct packed {
    comp_t x, y, z, w;
    logic has_known;
    norm_t known;
  } vec_row_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  comp_t x_in, y_in, z_in, w_in;
  logic [InW:0] length_out;
  unit_t unit_x, unit_y, unit_z, unit_w;
  logic zero_vector;

  norm_t pending_norms[$];
  bit failed;
  int idle_cycles;

  vec4_normalize uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_in(x_in), .y_in(y_in), .z_in(z_in), .w_in(w_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .length_out(length_out),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .unit_w(unit_w),
    .zero_vector(zero_vector)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] floor_sqrt(input logic [65:0] v);
    logic [65:0] root;
    logic [65:0] trial;
    root = 0;
    for (int b = 32; b >= 0; b--) begin
      trial = root | (66'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[63:0];
  endfunction

  function automatic unit_t unit_part(input comp_t c, input logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = c[InW-1] ? (64'd1 << InW) - {48'd0, c} : {48'd0, c};
    q = (mag << UFrac) / len;
    return c[InW-1] ? unit_t'(-q) : unit_t'(q);
  endfunction

  function automatic norm_t normalize(input comp_t x, y, z, w);
    norm_t r;
    logic [65:0] sum;
    logic [63:0] len;
    sum = 66'($signed(x) * $signed(x)) + 66'($signed(y) * $signed(y))
        + 66'($signed(z) * $signed(z)) + 66'($signed(w) * $signed(w));
    len = floor_sqrt(sum);
    r.length = len[InW:0];
    r.zero = (len == 0);
    if (r.zero) begin
      r.ux = 0; r.uy = 0; r.uz = 0; r.uw = 0;
    end else begin
      r.ux = unit_part(x, len);
      r.uy = unit_part(y, len);
      r.uz = unit_part(z, len);
      r.uw = unit_part(w, len);
    end
    return r;
  endfunction

  // Table rows: known zero, single-axis and all-negative extreme vectors, then rows checked against normalize().
  vec_row_t vec_table[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{17'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{16'sd256, 16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{17'd256, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{16'sd0, -16'sd256, 16'sd0, 16'sd0, 1'b1,
      '{17'd256, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 1'b0}},
    '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1,
      '{17'd65536, -16'sd8192, -16'sd8192, -16'sd8192, -16'sd8192, 1'b0}},
    '{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 1'b1,
      '{17'd32768, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 1'b0}},
    '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{17'd32767, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{17'd1, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{16'sd0, 16'sd0, -16'sd1, 16'sd0, 1'b1,
      '{17'd1, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 1'b0}},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
    '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b0, '0},
    '{16'sd1, -16'sd1, 16'sd1, 16'sd0, 1'b0, '0},
    '{-16'sd32768, 16'sd32767, -16'sd1, 16'sd1, 1'b0, '0},
    '{16'sd3, 16'sd4, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sh5555, -16'sh5556, 16'sh2AAA, -16'sh2AAB, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd1, 16'sd32767, 1'b0, '0}
  };

  task automatic send_vector(input comp_t x, y, z, w, input norm_t want);
    x_in <= x; y_in <= y; z_in <= z; w_in <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_norms.push_back(want);
    @(negedge clk);
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'($urandom_range(0, 4) - 2);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2: return comp_t'($urandom_range(0, 511) - 256);
      default: return comp_t'($urandom);
    endcase
  endfunction

  // Receiver: stalls in runs, with long stretches of none.
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 5) out_stall <= ~out_stall;
    else if ((($time / 2000) % 3) == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_norms.size() == 0) begin
        $display("%0t: unexpected result length=%0d", $time, length_out);
        failed = 1'b1;
      end else begin
        norm_t want;
        norm_t got;
        want = pending_norms.pop_front();
        got = '{length_out, unit_x, unit_y, unit_z, unit_w, zero_vector};
        if (got.length !== want.length)
          $display("%0t: length_out expected %0d got %0d", $time, want.length, got.length);
        if (got.ux !== want.ux)
          $display("%0t: unit_x expected %0d got %0d", $time, want.ux, got.ux);
        if (got.uy !== want.uy)
          $display("%0t: unit_y expected %0d got %0d", $time, want.uy, got.uy);
        if (got.uz !== want.uz)
          $display("%0t: unit_z expected %0d got %0d", $time, want.uz, got.uz);
        if (got.uw !== want.uw)
          $display("%0t: unit_w expected %0d got %0d", $time, want.uw, got.uw);
        if (got.zero !== want.zero)
          $display("%0t: zero_vector expected %0d got %0d", $time, want.zero, got.zero);
        if (got !== want) failed = 1'b1;
      end
    end
  end

  // Watchdog on cycles where neither side moves a transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    comp_t x, y, z, w;
    int burst;
    int sent;
    failed = 1'b0;
    idle_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    x_in = '0; y_in = '0; z_in = '0; w_in = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (vec_table[i]) begin
      send_vector(vec_table[i].x, vec_table[i].y, vec_table[i].z, vec_table[i].w,
                  vec_table[i].has_known ? vec_table[i].known
                  : normalize(vec_table[i].x, vec_table[i].y, vec_table[i].z,
                              vec_table[i].w));
      if (i == 7) begin
        in_valid <= 1'b0;
        wait (pending_norms.size() == 0);
        @(negedge clk);
      end
    end

    sent = 0;
    while (sent < NumRandom) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < NumRandom; k++) begin
        x = rand_comp(); y = rand_comp(); z = rand_comp(); w = rand_comp();
        send_vector(x, y, z, w, normalize(x, y, z, w));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    wait (pending_norms.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (!failed && pending_norms.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== vec4_normalize.f =====
rtl/v4n_pkg.sv
rtl/v4n_sqrt.sv
rtl/v4n_div.sv
rtl/vec4_normalize.sv
bench/tb_top.sv
